// ----- rtl/pwmc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmc_pkg
// Shared types, constants and the mask function of the payload word munge
// codec.
// ----------------------------------------------------------------------------
package pwmc_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned KEY_W   = 8;
  localparam int unsigned BLK_W   = 4;
  localparam int unsigned LANES   = 4;
  localparam int unsigned IN_DATA_W  = 40;  // key_byte, data_word
  localparam int unsigned IN_USER_W  = 3;   // mode, first_word, whole_word
  localparam int unsigned OUT_DATA_W = 32;  // result_word

  localparam logic [7:0] BASE_MASK_BYTE = 8'hA5;

  // Direction codes
  localparam logic MODE_MUNGE   = 1'b0;
  localparam logic MODE_UNMUNGE = 1'b1;

  typedef logic [7:0] byte_t;

  localparam byte_t MASK_TABLE [16] = '{
    8'h05, 8'h61, 8'h7A, 8'hED,
    8'h1B, 8'hCA, 8'h0D, 8'h9B,
    8'h4A, 8'hF1, 8'h64, 8'hC7,
    8'hB5, 8'h8E, 8'hDF, 8'hA0
  };

  // One registered input request, block index already resolved
  typedef struct packed {
    logic               mode;
    logic               whole;
    logic [KEY_W-1:0]   key;
    logic [WORD_W-1:0]  data;
    logic [BLK_W-1:0]   blk;
  } item_t;

  // Lane i: 0xA5 | (i << i) | i | table[(blk + i) mod 16]
  function automatic logic [WORD_W-1:0] mask_word(input logic [BLK_W-1:0] blk);
    logic [WORD_W-1:0] m;
    logic [BLK_W-1:0]  idx;
    logic [7:0]        lane_k;
    m = '0;
    for (int i = 0; i < LANES; i++) begin
      idx    = blk + BLK_W'(i);
      lane_k = (8'(i) << i) | 8'(i);
      m[8*i +: 8] = BASE_MASK_BYTE | lane_k | MASK_TABLE[idx];
    end
    return m;
  endfunction

  function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

// ----- rtl/pwmc_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmc_in_stage
// Input register and block counter: resolves each request's block index
// and holds the request until the result stage takes it.
// ----------------------------------------------------------------------------
module pwmc_in_stage
  import pwmc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_take,     // request accepted this cycle
  input  logic                  in_mode,
  input  logic                  in_first,
  input  logic                  in_whole,
  input  logic [KEY_W-1:0]      in_key,
  input  logic [WORD_W-1:0]     in_data,
  input  logic                  item_pop,    // held request moves on
  output logic                  item_valid,
  output item_t                 item
);

  logic              valid_r, valid_nxt;
  logic [BLK_W-1:0]  cnt_r, cnt_nxt;
  item_t             item_r, item_nxt;
  logic [BLK_W-1:0]  blk;

  // Block index: restart on a packet's first word
  always_comb begin
    blk      = in_first ? '0 : cnt_r;
    cnt_nxt  = cnt_r;
    item_nxt = item_r;
    valid_nxt = valid_r;
    if (item_pop) begin
      valid_nxt = 1'b0;
    end
    if (in_take) begin
      cnt_nxt        = in_whole ? blk + 1'b1 : blk;
      item_nxt.mode  = in_mode;
      item_nxt.whole = in_whole;
      item_nxt.key   = in_key;
      item_nxt.data  = in_data;
      item_nxt.blk   = blk;
      valid_nxt      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

`ifndef SYNTHESIS
  // A first word always works on block zero
  a_first_blk_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && in_first |=> item_r.blk == '0)
    else $error("first word not on block zero");

  // A whole word leaves the counter one past its own block
  a_whole_advances: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && in_whole |=> cnt_r == item_r.blk + 1'b1)
    else $error("counter did not advance past whole word");

  // A partial tail inside a packet leaves the counter alone
  a_tail_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && !in_whole && !in_first |=> $stable(cnt_r))
    else $error("counter moved on partial tail");
`endif

endmodule

// ----- rtl/pwmc_xform.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmc_xform
// Word transform: key XOR, byte swap and mask XOR in the order set by the
// direction, then XOR with the inverted key; partial tails pass through.
// ----------------------------------------------------------------------------
module pwmc_xform
  import pwmc_pkg::*;
(
  input  item_t              item,
  output logic [WORD_W-1:0]  result
);

  logic [WORD_W-1:0] key_w;
  logic [WORD_W-1:0] keyed;
  logic [WORD_W-1:0] pre;
  logic [WORD_W-1:0] masked;
  logic [WORD_W-1:0] post;

  always_comb begin
    key_w  = {{(WORD_W-KEY_W){1'b0}}, item.key};
    keyed  = item.data ^ key_w;
    // munge swaps before the mask, unmunge after it
    pre    = (item.mode == MODE_MUNGE) ? swap_bytes(keyed) : keyed;
    masked = pre ^ mask_word(item.blk);
    post   = (item.mode == MODE_UNMUNGE) ? swap_bytes(masked) : masked;
    result = item.whole ? (post ^ ~key_w) : item.data;
  end

endmodule

// ----- rtl/payload_word_munge_codec.sv -----
`timescale 1ns / 1ps
// Path: the input register holds each request, the result register its result word.
// Throughput: one word per cycle while out_tready is high; the single-pass XOR/swap datapath
// between the input and result registers takes a new word every cycle unless the result stage stalls.
// Reset: rst_n synchronous, active low; clears both valid flags and the
// block counter to zero. No configuration registers.
// ----------------------------------------------------------------------------
// payload_word_munge_codec
// Streams 32-bit payload words through the munge / unmunge transform.
// ----------------------------------------------------------------------------
module payload_word_munge_codec
  import pwmc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,   // [7:0] key_byte, [39:8] data_word
  input  logic [IN_USER_W-1:0]   in_tuser,   // [0] mode, [1] first_word, [2] whole_word
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata   // [31:0] result_word
);

  logic              in_take;
  logic              item_valid;
  item_t             item;
  logic              out_load;
  logic [WORD_W-1:0] result;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_data_r, out_data_nxt;

  // Pipeline flow: result stage loads when empty or being drained
  assign out_load  = item_valid && (!out_valid_r || out_tready);
  assign in_tready = !item_valid || out_load;
  assign in_take   = in_tvalid && in_tready;

  pwmc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_take    (in_take),
    .in_mode    (in_tuser[0]),
    .in_first   (in_tuser[1]),
    .in_whole   (in_tuser[2]),
    .in_key     (in_tdata[7:0]),
    .in_data    (in_tdata[39:8]),
    .item_pop   (out_load),
    .item_valid (item_valid),
    .item       (item)
  );

  pwmc_xform u_xform (
    .item   (item),
    .result (result)
  );

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // Partial tails reach the result register untouched
  a_tail_passes: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && !item.whole |=> out_data_r == $past(item.data))
    else $error("partial tail altered");

  // A held input request is never dropped while the result stage is full
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && out_valid_r && !out_tready |=> item_valid)
    else $error("held request lost");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for payload_word_munge_codec. Payload words are sent as
// directed cases and then as random packets, under three back-pressure
// profiles. A behavioural model of the munge / unmunge transform and the
// block counter predicts each result word. Results are compared in order.
// ----------------------------------------------------------------------------
module tb_top
  import pwmc_pkg::*;
();

  localparam int unsigned CLK_HALF     = 2;
  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned WORDS_PER_PHASE = 420;

  // tuser bit positions
  localparam int unsigned USER_MODE  = 0;
  localparam int unsigned USER_FIRST = 1;
  localparam int unsigned USER_WHOLE = 2;

  // Per-lane obfuscation table, indexed by (block + lane) mod 16
  localparam byte_t LANE_TABLE [16] = '{
    8'h05, 8'h61, 8'h7A, 8'hED,
    8'h1B, 8'hCA, 8'h0D, 8'h9B,
    8'h4A, 8'hF1, 8'h64, 8'hC7,
    8'hB5, 8'h8E, 8'hDF, 8'hA0
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [7:0] key_byte, [39:8] data_word
  logic [IN_USER_W-1:0]  in_tuser = '0;   // [0] mode, [1] first_word, [2] whole_word
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [31:0] result_word

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned err_count = 0;
  int unsigned cycles = 0;

  logic [WORD_W-1:0] expected_words [$];
  logic [BLK_W-1:0]  model_blk = '0;

  payload_word_munge_codec DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #(CLK_HALF) clk = ~clk;

  // Run time guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("payload_word_munge_codec regression: fail");
      $finish;
    end
  end

  // Result back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Expected word for one whole word at block index blk
  function automatic logic [WORD_W-1:0] munged_word(input logic m, input byte_t key,
                                                    input logic [WORD_W-1:0] d,
                                                    input logic [BLK_W-1:0] blk);
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] key32;
    logic [BLK_W-1:0]  idx;
    mask  = '0;
    key32 = {24'h0, key};
    for (int i = 0; i < 4; i++) begin
      idx = blk + BLK_W'(i);
      mask[8*i +: 8] = 8'hA5 | (8'(i) << i) | 8'(i) | LANE_TABLE[idx];
    end
    w = d ^ key32;
    if (m == MODE_MUNGE) w = {w[7:0], w[15:8], w[23:16], w[31:24]};
    w = w ^ mask;
    if (m == MODE_UNMUNGE) w = {w[7:0], w[15:8], w[23:16], w[31:24]};
    return w ^ ~key32;
  endfunction

  // Output check first, then prediction of the request taken at this edge
  always @(posedge clk) begin : monitor
    logic [BLK_W-1:0]  blk;
    logic [WORD_W-1:0] want;
    if (!rst_n) begin
      model_blk = '0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          $error("result_word: no result expected, got %h", out_tdata);
          err_count++;
        end else begin
          want = expected_words.pop_front();
          if (out_tdata !== want) begin
            $error("result_word: expected %h, got %h", want, out_tdata);
            err_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        blk = in_tuser[USER_FIRST] ? '0 : model_blk;
        if (!in_tuser[USER_WHOLE]) begin
          // partial tail passes through untouched
          model_blk = blk;
          expected_words.push_back(in_tdata[8 +: WORD_W]);
        end else begin
          model_blk = blk + 1'b1;
          expected_words.push_back(munged_word(in_tuser[USER_MODE], in_tdata[7:0],
                                               in_tdata[8 +: WORD_W], blk));
        end
      end
    end
  end

  // Send one request; entered and left at a falling edge
  task automatic send_word(input logic m, input byte_t key, input logic [WORD_W-1:0] d,
                           input logic first, input logic whole);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {d, key};
    in_tuser  <= {whole, first, m};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off the sender until every outstanding result is back
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  // Extremes, both directions, partial tails and counter wrap
  task automatic test_directed();
    send_word(MODE_MUNGE,   8'h00, 32'h0000_0000, 1'b1, 1'b1);
    send_word(MODE_MUNGE,   8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b1);
    send_word(MODE_UNMUNGE, 8'h00, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_word(MODE_UNMUNGE, 8'hFF, 32'h0000_0000, 1'b0, 1'b1);
    send_word(MODE_MUNGE,   8'hA5, 32'h0123_4567, 1'b0, 1'b0);  // tail keeps counter
    send_word(MODE_MUNGE,   8'hA5, 32'h89AB_CDEF, 1'b0, 1'b1);
    send_word(MODE_UNMUNGE, 8'h5A, 32'hDEAD_BEEF, 1'b1, 1'b0);  // tail clears counter
    send_word(MODE_UNMUNGE, 8'h5A, 32'hCAFE_F00D, 1'b0, 1'b1);
    // one packet long enough to wrap the block counter
    for (int w = 0; w < 18; w++)
      send_word(w[0] ? MODE_UNMUNGE : MODE_MUNGE, 8'h3C, $urandom, w == 0, 1'b1);
    wait_for_results();
  endtask

  // Mostly well-formed packets, some single noise requests
  task automatic test_random_packets(input int unsigned idle_send, input int unsigned idle_recv);
    int unsigned sent;
    int unsigned len;
    logic        m;
    byte_t       key;
    logic        paused;
    send_idle_pct = idle_send;
    recv_idle_pct = idle_recv;
    sent   = 0;
    paused = 1'b0;
    while (sent < WORDS_PER_PHASE) begin
      if ($urandom_range(0, 9) < 8) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 8);
        m   = 1'($urandom_range(0, 1));
        key = 8'($urandom);
        for (int unsigned w = 0; w < len; w++)
          send_word(m, key, $urandom, w == 0,
                    (w + 1 < len) || ($urandom_range(0, 2) != 0));
        sent += len;
      end else begin
        send_word(1'($urandom_range(0, 1)), 8'($urandom), $urandom,
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end
      if (!paused && sent >= WORDS_PER_PHASE / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
    end
    wait_for_results();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 28;
    recv_idle_pct = 74;
    test_directed();
    test_random_packets(28, 74);
    test_random_packets(74, 28);
    test_random_packets(0, 0);

    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("payload_word_munge_codec regression: pass");
    end else begin
      $display("payload_word_munge_codec regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/pwmc_pkg.sv
rtl/pwmc_in_stage.sv
rtl/pwmc_xform.sv
rtl/payload_word_munge_codec.sv
tb/sv/tb_top.sv
